### hdl/fsa_pkg.sv
// package for the free segment allocator: constants and status values
`timescale 1ns / 1ps
package fsa_pkg;
    localparam int AddrW = 15;
    localparam int DefPoolSize = 32767;
    localparam int DefTableEntries = 64;
    localparam logic [1:0] StOk = 2'd0;
    localparam logic [1:0] StAllocBad = 2'd1;
    localparam logic [1:0] StFreeBad = 2'd2;
    localparam logic [1:0] StFull = 2'd3;
    localparam logic KindAlloc = 1'b0;
    localparam logic KindFree = 1'b1;
    typedef logic [AddrW-1:0] t_addr;
endpackage

### hdl/fsa_ram.sv
// generic single port ram with registered read
`timescale 1ns / 1ps
module fsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // read before write, read data registered
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### hdl/free_segment_allocator.sv
// top level of the free segment allocator: table memory and scan sequencer
//
// channel   direction  handshake            payload
// request   in         start & !busy        i_kind, i_length, i_start_req
// result    out        o_done strobe        o_status, o_granted_start, o_largest_free
// config    in         i_fit_mode_we        i_fit_mode_wdata
//
// After reset a clearing pass writes every table entry, one per cycle,
// with busy held high.
// An allocate or a free passes, after accept, through a search scan, a decision,
// a write back, a scan for the largest length and the done cycle. A two-sided
// merge adds a second write back. A request bad on its fields alone is done in
// the cycle after accept, one rejected by the search after the search scan and
// the decision, with no write back.
// Busy stays high from accept until the done strobe; the receiver cannot stall.
`timescale 1ns / 1ps
module free_segment_allocator
    import fsa_pkg::*;
#(
    parameter int POOL_SIZE = DefPoolSize,
    parameter int TABLE_ENTRIES = DefTableEntries
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  logic         i_kind,
    input  logic [14:0]  i_length,
    input  logic [14:0]  i_start_req,
    input  logic         i_fit_mode_we,
    input  logic         i_fit_mode_wdata,
    output logic         o_done,
    output logic [1:0]   o_status,
    output logic [14:0]  o_granted_start,
    output logic [14:0]  o_largest_free
);
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = IW + 1;
    localparam int EW = 2 * AddrW + 1;
    localparam logic [AddrW:0] PoolW = (AddrW + 1)'(POOL_SIZE);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_DEC   = 4'd3;
    localparam logic [3:0] S_WR1   = 4'd4;
    localparam logic [3:0] S_WR2   = 4'd5;
    localparam logic [3:0] S_LSCAN = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;
    localparam logic [3:0] S_RD1   = 4'd8;

    // entry: {valid, start, length}
    logic          ram_we;
    logic [IW-1:0] ram_addr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    fsa_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_table (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(ram_wdata), .o_rdata(ram_rdata)
    );

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_rv, n_rv;
    logic [IW-1:0] r_ridx, n_ridx;
    logic          r_fit;
    logic          r_kind, n_kind;
    t_addr         r_len, n_len, r_a, n_a;
    logic [1:0]    r_stat, n_stat;
    t_addr         r_grant, n_grant;
    t_addr         r_lmax, n_lmax;
    logic          r_pk, n_pk;
    logic [IW-1:0] r_pi, n_pi;
    t_addr         r_ps, n_ps, r_pl, n_pl;
    logic          r_lo, n_lo, r_hi, n_hi, r_em, n_em;
    logic [IW-1:0] r_loi, n_loi, r_hii, n_hii, r_emi, n_emi;
    t_addr         r_los, n_los, r_lol, n_lol, r_hil, n_hil;
    logic          r_ovl, n_ovl;

    logic          e_v;
    t_addr         e_s, e_l;
    logic [AddrW:0] e_end, f_end;
    logic          better;

    assign e_v = ram_rdata[EW-1];
    assign e_s = ram_rdata[2*AddrW-1:AddrW];
    assign e_l = ram_rdata[AddrW-1:0];
    assign e_end = {1'b0, e_s} + {1'b0, e_l};
    assign f_end = {1'b0, r_a} + {1'b0, r_len};
    assign busy = (r_state != S_IDLE);

    // candidate compare for the allocate search
    always_comb begin
        if (!r_pk) begin
            better = 1'b1;
        end else if (!r_fit) begin
            better = e_s < r_ps;
        end else begin
            better = (e_l < r_pl) || ((e_l == r_pl) && (e_s < r_ps));
        end
    end

    // fit mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit <= 1'b0;
        end else if (i_fit_mode_we) begin
            r_fit <= i_fit_mode_wdata;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_rv = 1'b0; n_ridx = r_ridx;
        n_kind = r_kind; n_len = r_len; n_a = r_a; n_stat = r_stat;
        n_grant = r_grant; n_lmax = r_lmax; n_pk = r_pk; n_pi = r_pi;
        n_ps = r_ps; n_pl = r_pl; n_lo = r_lo; n_hi = r_hi; n_em = r_em;
        n_loi = r_loi; n_hii = r_hii; n_emi = r_emi; n_los = r_los;
        n_lol = r_lol; n_hil = r_hil; n_ovl = r_ovl;
        ram_we = 1'b0; ram_addr = r_cnt[IW-1:0]; ram_wdata = '0;
        o_done = 1'b0;
        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                ram_wdata = (r_cnt == '0) ? {1'b1, {AddrW{1'b0}}, PoolW[AddrW-1:0]} : '0;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(TABLE_ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_kind = i_kind; n_len = i_length; n_a = i_start_req;
                    n_grant = '0; n_pk = 1'b0; n_lo = 1'b0; n_hi = 1'b0;
                    n_em = 1'b0; n_ovl = 1'b0; n_cnt = '0;
                    if (i_kind == KindAlloc) begin
                        if (i_length == '0 || i_length > r_lmax) begin
                            n_stat = StAllocBad; n_state = S_OUT;
                        end else begin
                            n_stat = StOk; n_state = S_SCAN;
                        end
                    end else begin
                        if (i_length == '0 ||
                            ({1'b0, i_start_req} + {1'b0, i_length}) > PoolW) begin
                            n_stat = StFreeBad; n_state = S_OUT;
                        end else begin
                            n_stat = StOk; n_state = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN, S_LSCAN: begin
                // issue reads, evaluate data of the previous read
                if (r_cnt < CW'(TABLE_ENTRIES)) begin
                    ram_addr = r_cnt[IW-1:0];
                    n_rv = 1'b1; n_ridx = r_cnt[IW-1:0];
                    n_cnt = r_cnt + 1'b1;
                end
                if (r_rv) begin
                    if (r_state == S_LSCAN) begin
                        if (e_v && e_l > r_lmax) n_lmax = e_l;
                    end else if (r_kind == KindAlloc) begin
                        if (e_v && e_l >= r_len && better) begin
                            n_pk = 1'b1; n_pi = r_ridx; n_ps = e_s; n_pl = e_l;
                        end
                    end else if (!e_v) begin
                        if (!r_em) begin
                            n_em = 1'b1; n_emi = r_ridx;
                        end
                    end else begin
                        if ({1'b0, r_a} < e_end && {1'b0, e_s} < f_end) n_ovl = 1'b1;
                        if (e_end == {1'b0, r_a}) begin
                            n_lo = 1'b1; n_loi = r_ridx; n_los = e_s; n_lol = e_l;
                        end
                        if ({1'b0, e_s} == f_end) begin
                            n_hi = 1'b1; n_hii = r_ridx; n_hil = e_l;
                        end
                    end
                end
                if (!r_rv && r_cnt == CW'(TABLE_ENTRIES)) begin
                    n_state = (r_state == S_LSCAN) ? S_OUT : S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_WR1;
                if (r_kind == KindAlloc) begin
                    if (!r_pk) begin
                        n_stat = StAllocBad; n_state = S_OUT;
                    end
                end else if (r_ovl) begin
                    n_stat = StFreeBad; n_state = S_OUT;
                end else if (!r_lo && !r_hi && !r_em) begin
                    n_stat = StFull; n_state = S_OUT;
                end
            end
            S_WR1: begin
                ram_we = 1'b1;
                n_state = S_LSCAN; n_cnt = '0; n_lmax = '0;
                if (r_kind == KindAlloc) begin
                    ram_addr = r_pi;
                    n_grant = r_ps + (r_pl - r_len);
                    if (r_pl == r_len) ram_wdata = '0;
                    else ram_wdata = {1'b1, r_ps, t_addr'(r_pl - r_len)};
                end else if (r_lo) begin
                    ram_addr = r_loi;
                    ram_wdata = {1'b1, r_los,
                                 t_addr'(r_lol + r_len + (r_hi ? r_hil : '0))};
                    if (r_hi) begin
                        n_state = S_WR2; n_lmax = r_lmax;
                    end
                end else if (r_hi) begin
                    ram_addr = r_hii;
                    ram_wdata = {1'b1, r_a, t_addr'(r_hil + r_len)};
                end else begin
                    ram_addr = r_emi;
                    ram_wdata = {1'b1, r_a, r_len};
                end
            end
            S_WR2: begin
                ram_we = 1'b1; ram_addr = r_hii; ram_wdata = '0;
                n_state = S_LSCAN; n_cnt = '0; n_lmax = '0;
            end
            S_OUT: begin
                o_done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_cnt <= '0; r_rv <= 1'b0;
            r_lmax <= PoolW[AddrW-1:0];
        end else begin
            r_state <= n_state; r_cnt <= n_cnt; r_rv <= n_rv; r_lmax <= n_lmax;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ridx <= n_ridx; r_kind <= n_kind; r_len <= n_len; r_a <= n_a;
        r_stat <= n_stat; r_grant <= n_grant; r_pk <= n_pk; r_pi <= n_pi;
        r_ps <= n_ps; r_pl <= n_pl; r_lo <= n_lo; r_hi <= n_hi; r_em <= n_em;
        r_loi <= n_loi; r_hii <= n_hii; r_emi <= n_emi; r_los <= n_los;
        r_lol <= n_lol; r_hil <= n_hil; r_ovl <= n_ovl;
    end

    assign o_status = r_stat;
    assign o_granted_start = r_grant;
    assign o_largest_free = r_lmax;

    // a grant only comes with ok status
    a_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != StOk |-> o_granted_start == '0)
        else $error("grant on failed request");
    // done is followed by idle
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("not idle after done");
    // a failed request leaves the largest length unchanged
    a_lmax: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != StOk && $past(r_state) != S_CLEAR |-> $stable(r_lmax))
        else $error("largest changed on failure");
endmodule
